[src/snst_pkg.sv]
`default_nettype none
package snst_pkg;

    localparam int SNST_SLOTS = 8;

    localparam logic [2:0] ACT_STORE   = 3'd0;
    localparam logic [2:0] ACT_TAKE    = 3'd1;
    localparam logic [2:0] ACT_HAS     = 3'd2;
    localparam logic [2:0] ACT_HAS_ID  = 3'd3;
    localparam logic [2:0] ACT_CLR_ALL = 3'd4;
    localparam logic [2:0] ACT_CLR_DIG = 3'd5;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2,
        ST_NF   = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]   action;
        logic [255:0] digest;
        logic [31:0]  index;
        logic [7:0]   prefix;
        logic [255:0] key;
        logic [31:0]  handle;
    } t_item;

    typedef struct packed {
        logic    load;
        logic    match;
        logic    scan_start;
        logic    scan_step;
        logic    evict_rd;
        logic    evict;
        logic    write_free;
        logic    write_best;
        logic    take;
        logic    clr_all;
        logic    clr_dig;
        logic    res_ld;
        t_status res_code;
    } t_cmd;

    typedef struct packed {
        logic [2:0] action;
        logic       dup;
        logic       has_free;
        logic       has_cand;
        logic       hit;
        logic       scan_last;
        logic       out_free;
    } t_sts;

endpackage
`default_nettype wire

[src/snst_if.sv]
`default_nettype none
interface snst_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [63:0] digest_word0;
    logic [63:0] digest_word1;
    logic [63:0] digest_word2;
    logic [63:0] digest_word3;
    logic [31:0] input_number;
    logic [7:0]  pubkey_prefix;
    logic [63:0] pubkey_word0;
    logic [63:0] pubkey_word1;
    logic [63:0] pubkey_word2;
    logic [63:0] pubkey_word3;
    logic [31:0] nonce_handle;

    modport source (
        output valid, action, digest_word0, digest_word1, digest_word2, digest_word3,
               input_number, pubkey_prefix, pubkey_word0, pubkey_word1, pubkey_word2,
               pubkey_word3, nonce_handle,
        input  ready
    );
    modport sink (
        input  valid, action, digest_word0, digest_word1, digest_word2, digest_word3,
               input_number, pubkey_prefix, pubkey_word0, pubkey_word1, pubkey_word2,
               pubkey_word3, nonce_handle,
        output ready
    );
endinterface

interface snst_out_if;
    logic        valid;
    logic        ready;
    logic        success;
    logic [1:0]  status;
    logic [31:0] nonce_out;

    modport source (output valid, success, status, nonce_out, input ready);
    modport sink (input valid, success, status, nonce_out, output ready);
endinterface
`default_nettype wire

[src/snst_dp.sv]
`default_nettype none
module snst_dp #(
    parameter int SLOTS = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire snst_pkg::t_item i_item,
    input  wire snst_pkg::t_cmd  i_cmd,
    output snst_pkg::t_sts      o_sts,
    input  wire logic           i_out_ready,
    output logic                o_out_valid,
    output logic                o_success,
    output logic [1:0]          o_status,
    output logic [31:0]         o_nonce
);
    import snst_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_item              r_item;
    logic [SLOTS-1:0]   r_valid, n_valid;
    logic [31:0]        r_order  [SLOTS];
    logic [255:0]       r_sdig   [SLOTS];
    logic [31:0]        r_sidx   [SLOTS];
    logic [7:0]         r_spre   [SLOTS];
    logic [255:0]       r_skey   [SLOTS];
    logic [31:0]        r_shdl   [SLOTS];
    logic [31:0]        r_ctr;
    logic [SLOTS-1:0]   id_eq, dg_eq, r_id_eq, r_dg_eq;
    logic [SLOTS-1:0]   dupv, hitv, cand, od_eq;
    logic [IW-1:0]      free_idx, hit_idx, ws;
    logic [IW-1:0]      r_cnt, r_best;
    logic               r_best_ok;
    logic [31:0]        r_best_ord;
    logic [255:0]       r_od;
    logic               r_ovalid;
    t_status            r_status;
    logic [31:0]        r_nonce;

    function automatic logic [IW-1:0] f_first(input logic [SLOTS-1:0] v);
        logic [IW-1:0] r;
        r = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (v[i]) r = IW'(i);
        end
        return r;
    endfunction

    always_comb begin
        for (int s = 0; s < SLOTS; s++) begin
            id_eq[s] = r_valid[s] && r_sidx[s] == r_item.index &&
                       r_spre[s] == r_item.prefix && r_skey[s] == r_item.key;
            dg_eq[s] = r_sdig[s] == r_item.digest;
            od_eq[s] = r_valid[s] && r_sdig[s] == r_od;
        end
    end

    assign dupv     = r_id_eq & r_dg_eq;
    assign hitv     = r_id_eq & ((r_item.action == ACT_HAS_ID) ? {SLOTS{1'b1}} : r_dg_eq);
    assign cand     = r_valid & ~r_dg_eq;
    assign free_idx = f_first(~r_valid);
    assign hit_idx  = f_first(hitv);
    assign ws       = i_cmd.write_free ? free_idx : r_best;

    assign o_sts.action    = r_item.action;
    assign o_sts.dup       = |dupv;
    assign o_sts.has_free  = |(~r_valid);
    assign o_sts.has_cand  = |cand;
    assign o_sts.hit       = |hitv;
    assign o_sts.scan_last = r_cnt == IW'(SLOTS - 1);
    assign o_sts.out_free  = !r_ovalid || i_out_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_cmd.clr_all) n_valid = '0;
        if (i_cmd.clr_dig) n_valid = r_valid & ~r_dg_eq;
        if (i_cmd.take) n_valid[hit_idx] = 1'b0;
        if (i_cmd.evict) n_valid = r_valid & ~od_eq;
        if (i_cmd.write_free || i_cmd.write_best) n_valid[ws] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_ctr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_cmd.write_free || i_cmd.write_best) r_ctr <= r_ctr + 32'd1;
            if (i_cmd.res_ld) r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_item;
        if (i_cmd.match) begin
            r_id_eq <= id_eq;
            r_dg_eq <= dg_eq;
        end
        if (i_cmd.scan_start) begin
            r_cnt     <= '0;
            r_best_ok <= 1'b0;
        end else if (i_cmd.scan_step) begin
            if (cand[r_cnt] && (!r_best_ok || r_order[r_cnt] < r_best_ord)) begin
                r_best     <= r_cnt;
                r_best_ord <= r_order[r_cnt];
                r_best_ok  <= 1'b1;
            end
            r_cnt <= r_cnt + IW'(1);
        end
        if (i_cmd.evict_rd) r_od <= r_sdig[r_best];
        if (i_cmd.write_free || i_cmd.write_best) begin
            r_order[ws] <= r_ctr;
            r_sdig[ws]  <= r_item.digest;
            r_sidx[ws]  <= r_item.index;
            r_spre[ws]  <= r_item.prefix;
            r_skey[ws]  <= r_item.key;
            r_shdl[ws]  <= r_item.handle;
        end
        if (i_cmd.res_ld) begin
            r_status <= i_cmd.res_code;
            r_nonce  <= i_cmd.take ? r_shdl[hit_idx] : 32'd0;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_success   = r_status == ST_OK;
    assign o_status    = r_status;
    assign o_nonce     = r_nonce;
endmodule
`default_nettype wire

[src/snst_ctrl.sv]
`default_nettype none
module snst_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire snst_pkg::t_sts i_sts,
    output snst_pkg::t_cmd     o_cmd
);
    import snst_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MATCH  = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_SCAN   = 7'b0001000,
        S_EVRD   = 7'b0010000,
        S_EVICT  = 7'b0100000,
        S_FINISH = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_code = ST_NF;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MATCH;
                end
            end
            S_MATCH: begin
                o_cmd.match = 1'b1;
                n_state     = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.action == ACT_STORE && !i_sts.dup && !i_sts.has_free &&
                    i_sts.has_cand) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else if (i_sts.out_free) begin
                    o_cmd.res_ld = 1'b1;
                    n_state      = S_IDLE;
                    case (i_sts.action)
                        ACT_STORE: begin
                            if (i_sts.dup) o_cmd.res_code = ST_DUP;
                            else if (i_sts.has_free) begin
                                o_cmd.write_free = 1'b1;
                                o_cmd.res_code   = ST_OK;
                            end else o_cmd.res_code = ST_FULL;
                        end
                        ACT_TAKE, ACT_HAS, ACT_HAS_ID: begin
                            if (i_sts.hit) begin
                                o_cmd.res_code = ST_OK;
                                o_cmd.take     = i_sts.action == ACT_TAKE;
                            end
                        end
                        ACT_CLR_ALL: begin
                            o_cmd.clr_all  = 1'b1;
                            o_cmd.res_code = ST_OK;
                        end
                        ACT_CLR_DIG: begin
                            o_cmd.clr_dig  = 1'b1;
                            o_cmd.res_code = ST_OK;
                        end
                        default: o_cmd.res_code = ST_NF;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) n_state = S_EVRD;
            end
            S_EVRD: begin
                o_cmd.evict_rd = 1'b1;
                n_state        = S_EVICT;
            end
            S_EVICT: begin
                o_cmd.evict = 1'b1;
                n_state     = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.write_best = 1'b1;
                    o_cmd.res_ld     = 1'b1;
                    o_cmd.res_code   = ST_OK;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

[src/session_nonce_slot_table.sv]
`default_nettype none
// Fully associative nonce slot table. One request enters at a time and gives
// one result. Lookups, take, clears and stores into a free slot pass through
// the match and decide states and load the result register in the decide
// state, which waits while the output register still holds a result. A store
// into a full table that holds an entry of another session walks every slot
// once with a single stamp comparator to find the oldest such entry, evicts
// that session's entries and writes the new entry. The result sits in an
// output register, so the next request is taken while it waits.
module session_nonce_slot_table #(
    parameter int SLOTS = snst_pkg::SNST_SLOTS
) (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    snst_in_if.sink    i_in,
    snst_out_if.source o_out
);
    import snst_pkg::*;

    t_item item;
    t_cmd  cmd;
    t_sts  sts;

    assign item.action = i_in.action;
    assign item.digest = {i_in.digest_word0, i_in.digest_word1, i_in.digest_word2,
                          i_in.digest_word3};
    assign item.index  = i_in.input_number;
    assign item.prefix = i_in.pubkey_prefix;
    assign item.key    = {i_in.pubkey_word0, i_in.pubkey_word1, i_in.pubkey_word2,
                          i_in.pubkey_word3};
    assign item.handle = i_in.nonce_handle;

    snst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    snst_dp #(.SLOTS(SLOTS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_success   (o_out.success),
        .o_status    (o_out.status),
        .o_nonce     (o_out.nonce_out)
    );

`ifndef ASSERT_OFF
    a_load_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> cmd.match)
        else $error("transfer not followed by match");
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.res_ld |-> sts.out_free)
        else $error("result loaded over pending result");
    a_free_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.write_free |-> sts.has_free)
        else $error("write to free slot with none free");
    a_evict_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.evict |-> $past(cmd.evict_rd))
        else $error("evict without digest read");
`endif
endmodule
`default_nettype wire
